/* design/tsas_pkg.sv */
// Package of types, constants and reset values for the touch sample averaging and scaling block.
package tsas_pkg;

    localparam int CH_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 12;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_NUM    = 8;
    localparam int WRK_W      = 2 * VAL_W;
    localparam int STEP_W     = 5;

    localparam int SAMPLES_DEF = 8;

    localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(VAL_W);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(WRK_W);

    localparam logic [CH_W-1:0] CH_X  = 2'd0;
    localparam logic [CH_W-1:0] CH_Y  = 2'd1;
    localparam logic [CH_W-1:0] CH_Z1 = 2'd2;
    localparam logic [CH_W-1:0] CH_Z2 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW_EDGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH_EDGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW_EDGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH_EDGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCREEN_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCREEN_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCREEN_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCREEN_MAX = 3'd7;

    localparam logic [VAL_W-1:0] RST_X_LOW_EDGE   = 12'd200;
    localparam logic [VAL_W-1:0] RST_X_HIGH_EDGE  = 12'd3900;
    localparam logic [VAL_W-1:0] RST_Y_LOW_EDGE   = 12'd200;
    localparam logic [VAL_W-1:0] RST_Y_HIGH_EDGE  = 12'd3900;
    localparam logic [VAL_W-1:0] RST_X_SCREEN_MIN = 12'd0;
    localparam logic [VAL_W-1:0] RST_X_SCREEN_MAX = 12'd319;
    localparam logic [VAL_W-1:0] RST_Y_SCREEN_MIN = 12'd0;
    localparam logic [VAL_W-1:0] RST_Y_SCREEN_MAX = 12'd239;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MAP,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* design/touch_sample_average_scale.sv */
// Top level of the touch sample averaging and scaling block with its bit-serial datapath.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  input   | i_in_valid / o_in_ready   | i_channel, i_high_byte, i_low_byte
//  output  | o_out_valid / i_out_ready | o_result_channel, o_value
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_value
//
// A request that does not complete a run is added to the sum and leaves the block ready.
// A request that completes a run starts the average; Z1, Z2 and clamped X or Y then go to
// the output, X or Y inside the edges are scaled first: one shared shift register does the
// average division (16 steps), the scale multiply (12 steps) and the divide (24 steps).
// Synchronous active-low reset clears the run and loads the default calibration.
// A result waits in the output register; a stalled output holds the block in its last state.
module touch_sample_average_scale #(
    parameter int SAMPLES_PER_READING = tsas_pkg::SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tsas_pkg::CH_W-1:0]        i_channel,
    input  logic [tsas_pkg::BYTE_W-1:0]      i_high_byte,
    input  logic [tsas_pkg::BYTE_W-1:0]      i_low_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tsas_pkg::CH_W-1:0]        o_result_channel,
    output logic [tsas_pkg::VAL_W-1:0]       o_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tsas_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsas_pkg::VAL_W-1:0]       i_cfg_value
);
    import tsas_pkg::*;

    t_state r_state, n_state;

    logic [VAL_W-1:0]   r_cfg [CFG_NUM];
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [CH_W-1:0]    r_run_ch, n_run_ch;
    logic [WRK_W-1:0]   r_wrk, n_wrk;
    logic [VAL_W-1:0]   r_rem, n_rem;
    logic [VAL_W-1:0]   r_opd, n_opd;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [VAL_W-1:0]   r_val, n_val;
    logic               r_o_valid, n_o_valid;
    logic [CH_W-1:0]    r_o_ch, n_o_ch;
    logic [VAL_W-1:0]   r_o_value, n_o_value;

    logic               w_in_acc;
    logic [VAL_W-1:0]   w_sample;
    logic               w_same;
    logic [SUM_W-1:0]   w_sum_acc;
    logic [COUNT_W-1:0] w_cnt_acc;
    logic               w_full;
    logic               w_is_y;
    logic               w_is_z;
    logic [VAL_W-1:0]   w_lo;
    logic [VAL_W-1:0]   w_hi;
    logic [VAL_W-1:0]   w_factor;
    logic               w_at_hi;
    logic               w_at_lo;
    logic [VAL_W-1:0]   w_clamp;
    logic [VAL_W:0]     w_shift;
    logic [VAL_W+1:0]   w_diff;
    logic               w_ge;
    logic [VAL_W:0]     w_madd;
    logic               w_out_free;

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_o_valid;
    assign o_result_channel = r_o_ch;
    assign o_value          = r_o_value;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_sample   = {i_high_byte, i_low_byte[BYTE_W-1:BYTE_W-4]};
    assign w_same     = (i_channel == r_run_ch);
    assign w_sum_acc  = w_same ? (r_sum + SUM_W'(w_sample)) : SUM_W'(w_sample);
    assign w_cnt_acc  = w_same ? (r_count + COUNT_W'(1)) : COUNT_W'(1);
    assign w_full     = (w_cnt_acc == COUNT_W'(SAMPLES_PER_READING));
    assign w_out_free = !r_o_valid || i_out_ready;

    assign w_is_y   = (r_run_ch == CH_Y);
    assign w_is_z   = (r_run_ch == CH_Z1) || (r_run_ch == CH_Z2);
    assign w_lo     = w_is_y ? r_cfg[CFG_Y_LOW_EDGE] : r_cfg[CFG_X_LOW_EDGE];
    assign w_hi     = w_is_y ? r_cfg[CFG_Y_HIGH_EDGE] : r_cfg[CFG_X_HIGH_EDGE];
    assign w_factor = w_is_y ? r_cfg[CFG_Y_SCREEN_MAX] : r_cfg[CFG_X_SCREEN_MAX];
    assign w_at_hi  = (r_val >= w_hi);
    assign w_at_lo  = (r_val <= w_lo);

    always_comb begin
        if (w_is_y) begin
            w_clamp = w_at_hi ? r_cfg[CFG_Y_SCREEN_MIN] : r_cfg[CFG_Y_SCREEN_MAX];
        end else begin
            w_clamp = w_at_hi ? r_cfg[CFG_X_SCREEN_MAX] : r_cfg[CFG_X_SCREEN_MIN];
        end
    end

    // One restoring-divide step and one shift-add multiply step on the shared register.
    assign w_shift = {r_rem, r_wrk[WRK_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_opd};
    assign w_ge    = !w_diff[VAL_W+1];
    assign w_madd  = {1'b0, r_wrk[WRK_W-1:VAL_W]} + (r_wrk[0] ? {1'b0, r_opd} : {(VAL_W+1){1'b0}});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_full) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                if (r_cnt == '0) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (w_is_z || w_at_hi || w_at_lo) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cnt == '0) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_sum     = r_sum;
        n_count   = r_count;
        n_run_ch  = r_run_ch;
        n_wrk     = r_wrk;
        n_rem     = r_rem;
        n_opd     = r_opd;
        n_cnt     = r_cnt;
        n_val     = r_val;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_ch    = r_o_ch;
        n_o_value = r_o_value;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_run_ch = i_channel;
                    if (w_full) begin
                        n_sum   = '0;
                        n_count = '0;
                        n_wrk   = {w_sum_acc, {(WRK_W-SUM_W){1'b0}}};
                        n_rem   = '0;
                        n_opd   = VAL_W'(SAMPLES_PER_READING);
                        n_cnt   = AVG_STEPS;
                    end else begin
                        n_sum   = w_sum_acc;
                        n_count = w_cnt_acc;
                    end
                end
            end
            ST_AVG, ST_DIV: begin
                if (r_cnt == '0) begin
                    if (r_state == ST_AVG) begin
                        n_val = r_wrk[VAL_W-1:0];
                    end else if (w_is_y) begin
                        n_val = r_cfg[CFG_Y_SCREEN_MAX] - r_wrk[VAL_W-1:0];
                    end else begin
                        n_val = r_wrk[VAL_W-1:0];
                    end
                end else begin
                    n_wrk = {r_wrk[WRK_W-2:0], w_ge};
                    n_rem = w_ge ? w_diff[VAL_W-1:0] : w_shift[VAL_W-1:0];
                    n_cnt = r_cnt - STEP_W'(1);
                end
            end
            ST_MAP: begin
                if (w_at_hi || w_at_lo) begin
                    if (!w_is_z) begin
                        n_val = w_clamp;
                    end
                end
                n_wrk = {{VAL_W{1'b0}}, r_val - w_lo};
                n_rem = w_hi - w_lo;
                n_opd = w_factor;
                n_cnt = MUL_STEPS;
            end
            ST_MUL: begin
                if (r_cnt == '0) begin
                    n_opd = r_rem;
                    n_rem = '0;
                    n_cnt = DIV_STEPS;
                end else begin
                    n_wrk = {w_madd, r_wrk[VAL_W-1:1]};
                    n_cnt = r_cnt - STEP_W'(1);
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_ch    = r_run_ch;
                    n_o_value = r_val;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                 <= ST_IDLE;
            r_sum                   <= '0;
            r_count                 <= '0;
            r_run_ch                <= CH_X;
            r_cnt                   <= '0;
            r_o_valid               <= 1'b0;
            r_cfg[CFG_X_LOW_EDGE]   <= RST_X_LOW_EDGE;
            r_cfg[CFG_X_HIGH_EDGE]  <= RST_X_HIGH_EDGE;
            r_cfg[CFG_Y_LOW_EDGE]   <= RST_Y_LOW_EDGE;
            r_cfg[CFG_Y_HIGH_EDGE]  <= RST_Y_HIGH_EDGE;
            r_cfg[CFG_X_SCREEN_MIN] <= RST_X_SCREEN_MIN;
            r_cfg[CFG_X_SCREEN_MAX] <= RST_X_SCREEN_MAX;
            r_cfg[CFG_Y_SCREEN_MIN] <= RST_Y_SCREEN_MIN;
            r_cfg[CFG_Y_SCREEN_MAX] <= RST_Y_SCREEN_MAX;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_run_ch  <= n_run_ch;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg[i_cfg_index] <= i_cfg_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrk     <= n_wrk;
        r_rem     <= n_rem;
        r_opd     <= n_opd;
        r_val     <= n_val;
        r_o_ch    <= n_o_ch;
        r_o_value <= n_o_value;
    end

endmodule

/* sim/tsas_reading_checker.sv */
// Checker that predicts touch readings from accepted requests and compares the block's results.
`timescale 1ns / 100ps

module tsas_reading_checker #(
    parameter int SAMPLES = tsas_pkg::SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [tsas_pkg::CH_W-1:0]         i_channel,
    input  logic [tsas_pkg::BYTE_W-1:0]       i_high_byte,
    input  logic [tsas_pkg::BYTE_W-1:0]       i_low_byte,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [tsas_pkg::CH_W-1:0]         i_result_channel,
    input  logic [tsas_pkg::VAL_W-1:0]        i_value,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [tsas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsas_pkg::VAL_W-1:0]        i_cfg_value,
    output int                                o_pending,
    output int                                o_errors
);
    import tsas_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] value;
    } t_reading;

    t_reading          readings_due[$];
    logic [VAL_W-1:0]  cal [CFG_NUM];
    logic [SUM_W-1:0]  run_sum;
    logic [COUNT_W-1:0] run_count;
    logic [CH_W-1:0]   run_ch;
    int                mismatches = 0;

    function automatic logic [VAL_W-1:0] span_scale(input logic [VAL_W-1:0] factor,
                                                   input logic [VAL_W-1:0] avg,
                                                   input logic [VAL_W-1:0] lo,
                                                   input logic [VAL_W-1:0] hi);
        int span;
        span = int'(hi) - int'(lo);
        if (span <= 0) begin
            return '0;
        end
        return VAL_W'((int'(factor) * (int'(avg) - int'(lo))) / span);
    endfunction

    function automatic logic [VAL_W-1:0] screen_value(input logic [CH_W-1:0] ch,
                                                     input logic [VAL_W-1:0] avg);
        unique case (ch)
            CH_X: begin
                if (avg >= cal[CFG_X_HIGH_EDGE]) begin
                    return cal[CFG_X_SCREEN_MAX];
                end
                if (avg <= cal[CFG_X_LOW_EDGE]) begin
                    return cal[CFG_X_SCREEN_MIN];
                end
                return span_scale(cal[CFG_X_SCREEN_MAX], avg, cal[CFG_X_LOW_EDGE],
                                  cal[CFG_X_HIGH_EDGE]);
            end
            CH_Y: begin
                if (avg >= cal[CFG_Y_HIGH_EDGE]) begin
                    return cal[CFG_Y_SCREEN_MIN];
                end
                if (avg <= cal[CFG_Y_LOW_EDGE]) begin
                    return cal[CFG_Y_SCREEN_MAX];
                end
                return cal[CFG_Y_SCREEN_MAX] - span_scale(cal[CFG_Y_SCREEN_MAX], avg,
                                                          cal[CFG_Y_LOW_EDGE],
                                                          cal[CFG_Y_HIGH_EDGE]);
            end
            default: begin
                return avg;
            end
        endcase
    endfunction

    task automatic absorb_sample(input logic [CH_W-1:0] ch,
                                 input logic [BYTE_W-1:0] hi,
                                 input logic [BYTE_W-1:0] lo);
        logic [VAL_W-1:0] sample;
        logic [VAL_W-1:0] avg;
        t_reading         reading;
        sample = {hi, lo[7:4]};
        if (ch != run_ch) begin
            run_ch = ch;
            run_sum = '0;
            run_count = '0;
        end
        run_sum = run_sum + SUM_W'(sample);
        run_count = run_count + 1'b1;
        if (run_count >= SAMPLES) begin
            avg = VAL_W'(run_sum / SAMPLES);
            run_sum = '0;
            run_count = '0;
            reading.channel = ch;
            reading.value = screen_value(ch, avg);
            readings_due.push_back(reading);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading due;
        if (!i_rst_n) begin
            cal[CFG_X_LOW_EDGE]   = RST_X_LOW_EDGE;
            cal[CFG_X_HIGH_EDGE]  = RST_X_HIGH_EDGE;
            cal[CFG_Y_LOW_EDGE]   = RST_Y_LOW_EDGE;
            cal[CFG_Y_HIGH_EDGE]  = RST_Y_HIGH_EDGE;
            cal[CFG_X_SCREEN_MIN] = RST_X_SCREEN_MIN;
            cal[CFG_X_SCREEN_MAX] = RST_X_SCREEN_MAX;
            cal[CFG_Y_SCREEN_MIN] = RST_Y_SCREEN_MIN;
            cal[CFG_Y_SCREEN_MAX] = RST_Y_SCREEN_MAX;
            run_sum = '0;
            run_count = '0;
            run_ch = CH_X;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cal[i_cfg_index] = i_cfg_value;
            end
            if (i_in_valid && i_in_ready) begin
                absorb_sample(i_channel, i_high_byte, i_low_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual channel %0d value %0d",
                             $time, i_result_channel, i_value);
                end else begin
                    due = readings_due.pop_front();
                    if (i_result_channel !== due.channel) begin
                        mismatches++;
                        $display("%0t: result_channel mismatch, expected %0d, actual %0d",
                                 $time, due.channel, i_result_channel);
                    end
                    if (i_value !== due.value) begin
                        mismatches++;
                        $display("%0t: value mismatch on channel %0d, expected %0d, actual %0d",
                                 $time, due.channel, due.value, i_value);
                    end
                end
            end
        end
        o_pending <= readings_due.size();
        o_errors <= mismatches;
    end

endmodule

/* sim/tb_touch_sample_average_scale.sv */
// Testbench top that drives touch conversion requests and calibration writes and gives the verdict.
`timescale 1ns / 100ps

module tb_touch_sample_average_scale;
    import tsas_pkg::*;

    localparam int SAMPLES       = SAMPLES_DEF;
    localparam int ITEMS         = 850;
    localparam int PHASES        = 7;
    localparam int SETTLE_CYCLES = 100;
    localparam int LIMIT_NS      = 5_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CH_W-1:0]      channel = CH_X;
    logic [BYTE_W-1:0]    high_byte = '0;
    logic [BYTE_W-1:0]    low_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CH_W-1:0]      result_channel;
    logic [VAL_W-1:0]     value;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_X_LOW_EDGE;
    logic [VAL_W-1:0]     cfg_value = '0;
    int                   pending;
    int                   errors;
    bit                   quiet = 1'b0;
    int                   sent = 0;
    logic [VAL_W-1:0]     cal_now [CFG_NUM];

    touch_sample_average_scale #(
        .SAMPLES_PER_READING (SAMPLES)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_channel        (channel),
        .i_high_byte      (high_byte),
        .i_low_byte       (low_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_channel (result_channel),
        .o_value          (value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_value      (cfg_value)
    );

    tsas_reading_checker #(
        .SAMPLES (SAMPLES)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_channel        (channel),
        .i_high_byte      (high_byte),
        .i_low_byte       (low_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_channel (result_channel),
        .i_value          (value),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_value      (cfg_value),
        .o_pending        (pending),
        .o_errors         (errors)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 16);
    end

    task automatic send_item(input logic [CH_W-1:0] ch, input logic [BYTE_W-1:0] hi,
                             input logic [BYTE_W-1:0] lo);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        high_byte <= hi;
        low_byte <= lo;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_value <= val;
        cal_now[idx] = val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_calibration(input int xl, input int xh, input int yl, input int yh,
                                    input int xmin, input int xmax, input int ymin,
                                    input int ymax);
        write_cal(CFG_X_LOW_EDGE, VAL_W'(xl));
        write_cal(CFG_X_HIGH_EDGE, VAL_W'(xh));
        write_cal(CFG_Y_LOW_EDGE, VAL_W'(yl));
        write_cal(CFG_Y_HIGH_EDGE, VAL_W'(yh));
        write_cal(CFG_X_SCREEN_MIN, VAL_W'(xmin));
        write_cal(CFG_X_SCREEN_MAX, VAL_W'(xmax));
        write_cal(CFG_Y_SCREEN_MIN, VAL_W'(ymin));
        write_cal(CFG_Y_SCREEN_MAX, VAL_W'(ymax));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int aim_value(input logic [CH_W-1:0] ch);
        int edge_val;
        unique case ($urandom_range(0, 9))
            0: return 0;
            1: return 4095;
            2, 3, 4: return int'($urandom_range(0, 4095));
            default: begin
                if (ch == CH_X) begin
                    edge_val = $urandom_range(0, 1) ? int'(cal_now[CFG_X_LOW_EDGE])
                                                    : int'(cal_now[CFG_X_HIGH_EDGE]);
                end else if (ch == CH_Y) begin
                    edge_val = $urandom_range(0, 1) ? int'(cal_now[CFG_Y_LOW_EDGE])
                                                    : int'(cal_now[CFG_Y_HIGH_EDGE]);
                end else begin
                    edge_val = int'($urandom_range(0, 4095));
                end
                return edge_val + int'($urandom_range(0, 4)) - 2;
            end
        endcase
    endfunction

    task automatic send_run(input logic [CH_W-1:0] ch, input int len);
        int aim;
        int s;
        bit steady;
        aim = aim_value(ch);
        steady = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            s = steady ? aim : aim + int'($urandom_range(0, 16)) - 8;
            if (s < 0) begin
                s = 0;
            end
            if (s > 4095) begin
                s = 4095;
            end
            if ($urandom_range(0, 99) < 10) begin
                send_item(ch, BYTE_W'($urandom), BYTE_W'($urandom));
            end else begin
                send_item(ch, s[11:4], {s[3:0], 4'($urandom)});
            end
            sent++;
        end
    endtask

    initial begin
        int goal;
        int lo_e;
        logic [CH_W-1:0] ch;
        cal_now[CFG_X_LOW_EDGE]   = RST_X_LOW_EDGE;
        cal_now[CFG_X_HIGH_EDGE]  = RST_X_HIGH_EDGE;
        cal_now[CFG_Y_LOW_EDGE]   = RST_Y_LOW_EDGE;
        cal_now[CFG_Y_HIGH_EDGE]  = RST_Y_HIGH_EDGE;
        cal_now[CFG_X_SCREEN_MIN] = RST_X_SCREEN_MIN;
        cal_now[CFG_X_SCREEN_MAX] = RST_X_SCREEN_MAX;
        cal_now[CFG_Y_SCREEN_MIN] = RST_Y_SCREEN_MIN;
        cal_now[CFG_Y_SCREEN_MAX] = RST_Y_SCREEN_MAX;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // A full X run at the top of the range, then a Y run cut short by a Z2 run,
        // then a Y run at the bottom of the range with the low nibble set.
        for (int k = 0; k < SAMPLES; k++) begin
            send_item(CH_X, 8'hFF, 8'hFF);
        end
        for (int k = 0; k < 3; k++) begin
            send_item(CH_Y, 8'h55, 8'hAA);
        end
        for (int k = 0; k < SAMPLES; k++) begin
            send_item(CH_Z2, 8'h80, 8'h00);
        end
        for (int k = 0; k < SAMPLES; k++) begin
            send_item(CH_Y, 8'h00, 8'h0F);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            unique case (p)
                0: load_calibration(int'(RST_X_LOW_EDGE), int'(RST_X_HIGH_EDGE),
                                    int'(RST_Y_LOW_EDGE), int'(RST_Y_HIGH_EDGE),
                                    int'(RST_X_SCREEN_MIN), int'(RST_X_SCREEN_MAX),
                                    int'(RST_Y_SCREEN_MIN), int'(RST_Y_SCREEN_MAX));
                1: load_calibration(0, 4095, 0, 4095, 0, 4095, 0, 4095);
                2: load_calibration(3000, 1000, 3500, 500, $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095));
                3: load_calibration(2048, 2048, 2048, 2048, 4095, 0, 4095, 0);
                default: begin
                    lo_e = int'($urandom_range(0, 2000));
                    load_calibration(lo_e, $urandom_range(2100, 4095), $urandom_range(0, 2000),
                                     $urandom_range(2100, 4095), $urandom_range(0, 4095),
                                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                                     $urandom_range(0, 4095));
                end
            endcase
            quiet = (p == 1);
            goal = sent + ITEMS / PHASES;
            while (sent < goal) begin
                ch = CH_W'($urandom);
                if ($urandom_range(0, 99) < 80) begin
                    send_run(ch, SAMPLES);
                end else begin
                    send_run(ch, $urandom_range(1, SAMPLES - 1));
                end
            end
        end

        quiet = 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/tsas_pkg.sv
design/touch_sample_average_scale.sv
sim/tsas_reading_checker.sv
sim/tb_touch_sample_average_scale.sv
